/* rtl/otrt_pkg.sv */
`default_nettype none

package otrt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int TREE_LEVELS = $clog2(TABLE_DEPTH);
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;

   // field widths
   localparam int ENTRY_W    = 32;
   localparam int AMOUNT_W   = 20;
   localparam int ANSWER_W   = 31;
   localparam int STORED_W   = 11;
   localparam int DEPARTED_W = 24;
   localparam logic [DEPARTED_W-1:0] DEPARTED_MAX = {DEPARTED_W{1'b1}};

   // configuration port
   localparam int   CSR_ADDR_W    = 3;
   localparam int   CSR_DATA_W    = 32;
   localparam logic REG_MIN_VALUE = 1'b0;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_ADD      = 2'd1,
      OP_SUBTRACT = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   // what the cell row does in a given cycle
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_PRUNE  = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_KEY   = 3'd1,
      ST_CELLS = 3'd2,
      ST_WAIT  = 3'd3,
      ST_DONE  = 3'd4
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      mode_type                  mode;
      logic signed [ENTRY_W-1:0] key;
      logic [IDX_W-1:0]          rank;
      logic [CNT_W-1:0]          count;
   } cell_cmd_type;

endpackage

`default_nettype wire

/* rtl/otrt_cell.sv */
`default_nettype none

module otrt_cell (
   input  wire logic                          clock,
   input  wire logic [otrt_pkg::IDX_W-1:0]    cell_idx,
   input  wire otrt_pkg::cell_cmd_type        cmd,
   input  wire logic [otrt_pkg::ENTRY_W-1:0]  prev_entry,
   input  wire logic                          prev_hold,
   input  wire logic                          next_hold,
   output logic [otrt_pkg::ENTRY_W-1:0]       entry,
   output logic                               hold,
   output logic [otrt_pkg::ENTRY_W-1:0]       leaf
);
   import otrt_pkg::*;

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [ENTRY_W-1:0] leaf_ff, leaf_in;
   logic               occupied;

   // slot holds a live entry when it lies below the count
   assign occupied = (IDX_W+1)'(cell_idx) < (IDX_W+1)'(cmd.count);
   assign hold     = occupied && ($signed(entry_ff) >= $signed(cmd.key));

   // insert: keep, take the new key, or take the neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (cmd.mode == MODE_INSERT && !hold) begin
         entry_in = prev_hold ? $unsigned(cmd.key) : prev_entry;
      end
   end

   // tree leaf: new count boundary on prune, selected entry on query
   always_comb begin
      case (cmd.mode)
         MODE_PRUNE: begin
            leaf_in = (hold && !next_hold) ? ENTRY_W'(cell_idx) + ENTRY_W'(1) : '0;
         end
         MODE_QUERY: begin
            leaf_in = (cell_idx == cmd.rank) ? entry_ff : '0;
         end
         default: begin
            leaf_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      leaf_ff  <= leaf_in;
   end

   assign entry = entry_ff;
   assign leaf  = leaf_ff;

endmodule

`default_nettype wire

/* rtl/otrt_or_tree.sv */
`default_nettype none

module otrt_or_tree (
   input  wire logic                         clock,
   input  wire logic [otrt_pkg::ENTRY_W-1:0] leaf [otrt_pkg::TABLE_DEPTH],
   output logic [otrt_pkg::ENTRY_W-1:0]      root
);
   import otrt_pkg::*;

   // heap layout: node k combines children 2k and 2k+1, one register per level
   logic [ENTRY_W-1:0] node_ff [1:TREE_LEAVES-1];

   for (genvar k = 1; k < TREE_LEAVES; k++) begin : g_node
      logic [ENTRY_W-1:0] left_w, right_w;

      if (2 * k >= TREE_LEAVES) begin : g_bottom
         if (2 * k - TREE_LEAVES < TABLE_DEPTH) begin : g_left
            assign left_w = leaf[2 * k - TREE_LEAVES];
         end else begin : g_left_pad
            assign left_w = '0;
         end
         if (2 * k + 1 - TREE_LEAVES < TABLE_DEPTH) begin : g_right
            assign right_w = leaf[2 * k + 1 - TREE_LEAVES];
         end else begin : g_right_pad
            assign right_w = '0;
         end
      end else begin : g_inner
         assign left_w  = node_ff[2 * k];
         assign right_w = node_ff[2 * k + 1];
      end

      always_ff @(posedge clock) begin
         node_ff[k] <= left_w | right_w;
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

/* rtl/offset_threshold_rank_table_core.sv */
// Channel  | Direction | Handshake              | Beat
// req      | in        | req_valid / req_stall  | operation, amount
// rsp      | out       | rsp_valid / rsp_stall  | query answer, flags, counts
// csr      | in        | APB, pready tied high  | min_value at byte address 0
//
// Path per item: add, rejected or full insert, rank zero or short query: idle, done.
// Accepted insert: idle, key, cells, done. Answered query: idle, cells, wait, done;
// subtract: idle, key, cells, wait, done. Wait tracks the registered OR tree on the cell row.
// Reset is synchronous; counters and offset clear, table slots are not cleared.
// A result waits in the output register under rsp_stall; the next item is taken
// meanwhile and then holds in its last cycle until the output register frees.
`default_nettype none

module offset_threshold_rank_table_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_operation,
   input  wire logic [otrt_pkg::AMOUNT_W-1:0]    req_amount,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_answer_valid,
   output logic                                  rsp_not_enough,
   output logic [otrt_pkg::ANSWER_W-1:0]         rsp_answer,
   output logic                                  rsp_insert_rejected,
   output logic                                  rsp_table_full,
   output logic [otrt_pkg::STORED_W-1:0]         rsp_stored_count,
   output logic [otrt_pkg::DEPARTED_W-1:0]       rsp_departed_count,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [otrt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [otrt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [otrt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import otrt_pkg::*;

   localparam int WAIT_W = $clog2(TREE_LEVELS + 1);
   localparam logic signed [32:0] OFF_HI = 33'sd1073741824;
   localparam logic signed [32:0] OFF_LO = -33'sd1073741824;
   localparam logic signed [32:0] ANS_HI = 33'sd2147483647;

   // control and arithmetic state
   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [AMOUNT_W-1:0]       amount_ff, amount_in;
   logic signed [ENTRY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]          rank_ff, rank_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [ENTRY_W-1:0] offset_ff, offset_in;
   logic [DEPARTED_W-1:0]     departed_ff, departed_in;
   logic [AMOUNT_W-1:0]       min_ff;
   logic [WAIT_W-1:0]         wait_ff, wait_in;

   // per-item result flags
   logic                      ans_valid_ff, ans_valid_in;
   logic                      short_ff, short_in;
   logic [ANSWER_W-1:0]       answer_ff, answer_in;
   logic                      rejected_ff, rejected_in;
   logic                      full_ff, full_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ans_valid_ff;
   logic                      rsp_short_ff;
   logic [ANSWER_W-1:0]       rsp_answer_ff;
   logic                      rsp_rejected_ff;
   logic                      rsp_full_ff;
   logic [STORED_W-1:0]       rsp_stored_ff;
   logic [DEPARTED_W-1:0]     rsp_departed_ff;
   logic                      rsp_load;

   // cell row
   cell_cmd_type              cmd;
   logic [ENTRY_W-1:0]        entry_w [TABLE_DEPTH];
   logic [ENTRY_W-1:0]        leaf_w  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    hold_w;
   logic [ENTRY_W-1:0]        root_w;

   // datapath helpers
   logic signed [32:0]        amount_s, amount_ff_s, min_s, offset_s;
   logic signed [32:0]        off_up, off_down, ins_key, prune_key, actual;
   logic [AMOUNT_W-1:0]       rank_full;
   logic [CNT_W-1:0]          new_count, dropped;
   logic [DEPARTED_W:0]       departed_sum;
   logic [CNT_W+STORED_W-1:0] stored_ext;
   logic                      csr_write;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
      end else if (csr_write && csr_paddr[2] == REG_MIN_VALUE) begin
         min_ff <= csr_pwdata[AMOUNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MIN_VALUE) ?
                       CSR_DATA_W'(min_ff) : '0;

   // ------------------------------------------------------------------
   // offset and key arithmetic
   // ------------------------------------------------------------------
   assign amount_s    = $signed({13'd0, req_amount});
   assign amount_ff_s = $signed({13'd0, amount_ff});
   assign min_s       = $signed({13'd0, min_ff});
   assign offset_s    = 33'(offset_ff);

   always_comb begin
      off_up = offset_s + amount_s;
      if (off_up > OFF_HI) begin
         off_up = OFF_HI;
      end
      off_down = offset_s - amount_s;
      if (off_down < OFF_LO) begin
         off_down = OFF_LO;
      end
   end

   assign ins_key   = amount_ff_s - offset_s;
   assign prune_key = min_s - offset_s;
   assign rank_full = req_amount - AMOUNT_W'(1);

   // query answer: stored entry seen through the offset, clamped
   always_comb begin
      actual = 33'($signed(root_w)) + offset_s;
      if (actual < 33'sd0) begin
         actual = 33'sd0;
      end else if (actual > ANS_HI) begin
         actual = ANS_HI;
      end
   end

   // prune bookkeeping
   assign new_count    = root_w[CNT_W-1:0];
   assign dropped      = count_ff - new_count;
   assign departed_sum = {1'b0, departed_ff} + (DEPARTED_W+1)'(dropped);

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      amount_in    = amount_ff;
      key_in       = key_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      departed_in  = departed_ff;
      wait_in      = wait_ff;
      ans_valid_in = ans_valid_ff;
      short_in     = short_ff;
      answer_in    = answer_ff;
      rejected_in  = rejected_ff;
      full_in      = full_ff;
      rsp_load     = 1'b0;
      req_stall    = 1'b1;
      cmd.mode     = MODE_IDLE;
      cmd.key      = key_ff;
      cmd.rank     = rank_ff;
      cmd.count    = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in        = op_type'(req_operation);
               amount_in    = req_amount;
               ans_valid_in = 1'b0;
               short_in     = 1'b0;
               answer_in    = '0;
               rejected_in  = 1'b0;
               full_in      = 1'b0;
               unique case (op_type'(req_operation))
                  OP_INSERT: begin
                     if (req_amount < min_ff) begin
                        rejected_in = 1'b1;
                        state_in    = ST_DONE;
                     end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        full_in  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_KEY;
                     end
                  end
                  OP_ADD: begin
                     offset_in = $signed(off_up[ENTRY_W-1:0]);
                     state_in  = ST_DONE;
                  end
                  OP_SUBTRACT: begin
                     offset_in = $signed(off_down[ENTRY_W-1:0]);
                     state_in  = ST_KEY;
                  end
                  OP_QUERY: begin
                     if (req_amount == '0) begin
                        state_in = ST_DONE;
                     end else if (32'(req_amount) > 32'(count_ff)) begin
                        short_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        rank_in  = rank_full[IDX_W-1:0];
                        state_in = ST_CELLS;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_KEY: begin
            key_in   = (op_ff == OP_INSERT) ? $signed(ins_key[ENTRY_W-1:0]) :
                                              $signed(prune_key[ENTRY_W-1:0]);
            state_in = ST_CELLS;
         end
         ST_CELLS: begin
            unique case (op_ff)
               OP_INSERT: begin
                  cmd.mode = MODE_INSERT;
                  count_in = count_ff + CNT_W'(1);
                  state_in = ST_DONE;
               end
               OP_SUBTRACT: begin
                  cmd.mode = MODE_PRUNE;
                  wait_in  = WAIT_W'(TREE_LEVELS);
                  state_in = ST_WAIT;
               end
               default: begin
                  cmd.mode = MODE_QUERY;
                  wait_in  = WAIT_W'(TREE_LEVELS);
                  state_in = ST_WAIT;
               end
            endcase
         end
         ST_WAIT: begin
            if (wait_ff == '0) begin
               if (op_ff == OP_SUBTRACT) begin
                  count_in    = new_count;
                  departed_in = (departed_sum > (DEPARTED_W+1)'(DEPARTED_MAX)) ?
                                DEPARTED_MAX : departed_sum[DEPARTED_W-1:0];
               end else begin
                  ans_valid_in = 1'b1;
                  answer_in    = actual[ANSWER_W-1:0];
               end
               state_in = ST_DONE;
            end else begin
               wait_in = wait_ff - WAIT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         offset_ff   <= '0;
         departed_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         departed_ff <= departed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      amount_ff    <= amount_in;
      key_ff       <= key_in;
      rank_ff      <= rank_in;
      wait_ff      <= wait_in;
      ans_valid_ff <= ans_valid_in;
      short_ff     <= short_in;
      answer_ff    <= answer_in;
      rejected_ff  <= rejected_in;
      full_ff      <= full_in;
   end

   // ------------------------------------------------------------------
   // cell row and collection tree
   // ------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [ENTRY_W-1:0] prev_entry_w;
      logic               prev_hold_w, next_hold_w;

      if (i == 0) begin : g_head
         assign prev_entry_w = $unsigned(key_ff);
         assign prev_hold_w  = 1'b1;
      end else begin : g_body
         assign prev_entry_w = entry_w[i-1];
         assign prev_hold_w  = hold_w[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_hold_w = 1'b0;
      end else begin : g_link
         assign next_hold_w = hold_w[i+1];
      end

      otrt_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .cmd        (cmd),
         .prev_entry (prev_entry_w),
         .prev_hold  (prev_hold_w),
         .next_hold  (next_hold_w),
         .entry      (entry_w[i]),
         .hold       (hold_w[i]),
         .leaf       (leaf_w[i])
      );
   end

   otrt_or_tree u_tree (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root_w)
   );

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign stored_ext   = {STORED_W'(0), count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ans_valid_ff <= ans_valid_ff;
         rsp_short_ff     <= short_ff;
         rsp_answer_ff    <= answer_ff;
         rsp_rejected_ff  <= rejected_ff;
         rsp_full_ff      <= full_ff;
         rsp_stored_ff    <= stored_ext[STORED_W-1:0];
         rsp_departed_ff  <= departed_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_answer_valid    = rsp_ans_valid_ff;
   assign rsp_not_enough      = rsp_short_ff;
   assign rsp_answer          = rsp_answer_ff;
   assign rsp_insert_rejected = rsp_rejected_ff;
   assign rsp_table_full      = rsp_full_ff;
   assign rsp_stored_count    = rsp_stored_ff;
   assign rsp_departed_count  = rsp_departed_ff;

`ifndef SYNTHESIS
   // count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // an insert only reaches the cell row with a free slot
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELLS && op_ff == OP_INSERT) |-> count_ff < CNT_W'(TABLE_DEPTH))
      else $error("insert shifted into a full row");

   // pruning never grows the table
   a_prune_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && wait_ff == '0 && op_ff == OP_SUBTRACT)
      |=> count_ff <= $past(count_ff))
      else $error("prune raised the entry count");

   // departed total never falls
   a_departed_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> departed_ff >= $past(departed_ff))
      else $error("departed total decreased");

   // a result is never both answered and short
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ans_valid_ff && rsp_short_ff))
      else $error("answer and not-enough both set");
`endif

endmodule

`default_nettype wire

/* test/offset_threshold_rank_table_checker.sv */
`timescale 1ns / 1ps

module offset_threshold_rank_table_checker
   import otrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [AMOUNT_W-1:0]   req_amount,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_answer_valid,
   input  logic                  rsp_not_enough,
   input  logic [ANSWER_W-1:0]   rsp_answer,
   input  logic                  rsp_insert_rejected,
   input  logic                  rsp_table_full,
   input  logic [STORED_W-1:0]   rsp_stored_count,
   input  logic [DEPARTED_W-1:0] rsp_departed_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   localparam logic [CSR_ADDR_W-1:0] MIN_VALUE_ADDR = CSR_ADDR_W'(4 * REG_MIN_VALUE);
   localparam longint OFFSET_LIMIT = 64'sd1073741824;
   localparam longint ANSWER_CEIL  = 64'sd2147483647;

   typedef struct packed {
      logic                  answer_valid;
      logic                  not_enough;
      logic [ANSWER_W-1:0]   answer;
      logic                  insert_rejected;
      logic                  table_full;
      logic [STORED_W-1:0]   stored_count;
      logic [DEPARTED_W-1:0] departed_count;
   } rank_reply_t;

   // shadow of the table, stored relative to the shared offset
   logic signed [ENTRY_W-1:0] sorted_entries [TABLE_DEPTH];
   int unsigned               held_count;
   longint                    shared_offset;
   logic [DEPARTED_W-1:0]     pruned_total;
   logic [AMOUNT_W-1:0]       floor_value;
   rank_reply_t               due_replies [$];

   // run statistics
   int          replies_checked;
   int          ranked_answers;
   int          ceiling_answers;
   int          short_ranks;
   int          below_floor;
   int          full_drops;
   int unsigned peak_held;
   longint      lowest_offset;
   longint      highest_offset;

   // apply one beat to the shadow table and return the reply it owes
   function automatic rank_reply_t apply_beat(op_type op, logic [AMOUNT_W-1:0] amount);
      rank_reply_t reply;
      longint      stored;
      longint      actual;
      int unsigned pos;
      reply = '0;
      case (op)
         OP_INSERT: begin
            if (amount < floor_value) begin
               reply.insert_rejected = 1'b1;
            end else if (held_count >= TABLE_DEPTH) begin
               reply.table_full = 1'b1;
            end else begin
               // equal values: the newcomer lands behind its peers
               stored = longint'(amount) - shared_offset;
               pos = 0;
               while (pos < held_count && longint'(sorted_entries[pos]) >= stored)
                  pos++;
               for (int i = held_count; i > pos; i--)
                  sorted_entries[i] = sorted_entries[i - 1];
               sorted_entries[pos] = ENTRY_W'(stored);
               held_count++;
            end
         end
         OP_ADD: begin
            shared_offset += longint'(amount);
            if (shared_offset > OFFSET_LIMIT)
               shared_offset = OFFSET_LIMIT;
         end
         OP_SUBTRACT: begin
            shared_offset -= longint'(amount);
            if (shared_offset < -OFFSET_LIMIT)
               shared_offset = -OFFSET_LIMIT;
            // the lowest entries sit at the tail, drop them against the floor
            while (held_count > 0 && longint'(sorted_entries[held_count - 1]) + shared_offset
                   < longint'(floor_value)) begin
               held_count--;
               if (pruned_total != DEPARTED_MAX)
                  pruned_total++;
            end
         end
         default: begin
            // rank zero reports neither an answer nor a shortfall
            if (amount != 0) begin
               if (amount > held_count) begin
                  reply.not_enough = 1'b1;
               end else begin
                  actual = longint'(sorted_entries[amount - 1'b1]) + shared_offset;
                  if (actual < 0)
                     actual = 0;
                  if (actual > ANSWER_CEIL)
                     actual = ANSWER_CEIL;
                  reply.answer_valid = 1'b1;
                  reply.answer       = ANSWER_W'(actual);
               end
            end
         end
      endcase
      reply.stored_count   = STORED_W'(held_count);
      reply.departed_count = pruned_total;
      return reply;
   endfunction

   function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
      end
   endfunction

   function void report_coverage();
      $display("checked %0d replies: %0d ranked answers (%0d clamped at the ceiling), %0d short ranks, %0d inserts under the floor, %0d into a full table",
               replies_checked, ranked_answers, ceiling_answers, short_ranks, below_floor,
               full_drops);
      $display("peak occupancy %0d of %0d, %0d entries pruned, offset swept %0d .. %0d",
               peak_held, TABLE_DEPTH, pruned_total, lowest_offset, highest_offset);
   endfunction

   always @(posedge clock) begin : monitor
      rank_reply_t want;
      if (reset) begin
         held_count     = 0;
         shared_offset  = 0;
         pruned_total   = '0;
         floor_value    = '0;
         lowest_offset  = 0;
         highest_offset = 0;
         due_replies.delete();
      end else begin
         // configuration port
         if (csr_psel && csr_penable && csr_pready && csr_paddr == MIN_VALUE_ADDR) begin
            if (csr_pwrite) begin
               floor_value = csr_pwdata[AMOUNT_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(floor_value)) begin
               fail_count++;
               $display("%0t: min_value readback mismatch, expected 0x%0h, got 0x%0h",
                        $time, floor_value, csr_prdata);
            end
         end

         // request beat
         if (req_valid && !req_stall) begin
            due_replies.push_back(apply_beat(op_type'(req_operation), req_amount));
            if (held_count > peak_held)
               peak_held = held_count;
            if (shared_offset < lowest_offset)
               lowest_offset = shared_offset;
            if (shared_offset > highest_offset)
               highest_offset = shared_offset;
         end

         // response beat
         if ($isunknown(rsp_valid)) begin
            fail_count++;
            $display("%0t: rsp_valid is unknown", $time);
         end else if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               fail_count++;
               $display("%0t: reply arrived with no request outstanding", $time);
            end else begin
               want = due_replies.pop_front();
               compare_field("answer_valid", want.answer_valid, rsp_answer_valid);
               compare_field("not_enough", want.not_enough, rsp_not_enough);
               compare_field("answer", want.answer, rsp_answer);
               compare_field("insert_rejected", want.insert_rejected, rsp_insert_rejected);
               compare_field("table_full", want.table_full, rsp_table_full);
               compare_field("stored_count", want.stored_count, rsp_stored_count);
               compare_field("departed_count", want.departed_count, rsp_departed_count);
               replies_checked++;
               if (want.answer_valid)
                  ranked_answers++;
               if (want.answer_valid && want.answer == '1)
                  ceiling_answers++;
               if (want.not_enough)
                  short_ranks++;
               if (want.insert_rejected)
                  below_floor++;
               if (want.table_full)
                  full_drops++;
            end
         end
      end
      pending = due_replies.size();
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import otrt_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MIN_VALUE_ADDR = CSR_ADDR_W'(4 * REG_MIN_VALUE);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = TREE_LEVELS + 20;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_operation = OP_INSERT;
   logic [AMOUNT_W-1:0]   req_amount = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_answer_valid;
   logic                  rsp_not_enough;
   logic [ANSWER_W-1:0]   rsp_answer;
   logic                  rsp_insert_rejected;
   logic                  rsp_table_full;
   logic [STORED_W-1:0]   rsp_stored_count;
   logic [DEPARTED_W-1:0] rsp_departed_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending;

   // sender state
   int                    burst_left = 4;
   bit                    steady = 1'b0;
   bit                    offering = 1'b0;
   bit                    hold_request = 1'b0;
   logic [AMOUNT_W-1:0]   floor_setting = '0;

   always #1 clock = ~clock;

   offset_threshold_rank_table_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_amount          (req_amount),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_answer_valid    (rsp_answer_valid),
      .rsp_not_enough      (rsp_not_enough),
      .rsp_answer          (rsp_answer),
      .rsp_insert_rejected (rsp_insert_rejected),
      .rsp_table_full      (rsp_table_full),
      .rsp_stored_count    (rsp_stored_count),
      .rsp_departed_count  (rsp_departed_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   offset_threshold_rank_table_checker watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_amount          (req_amount),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_answer_valid    (rsp_answer_valid),
      .rsp_not_enough      (rsp_not_enough),
      .rsp_answer          (rsp_answer),
      .rsp_insert_rejected (rsp_insert_rejected),
      .rsp_table_full      (rsp_table_full),
      .rsp_stored_count    (rsp_stored_count),
      .rsp_departed_count  (rsp_departed_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // offer one beat from a falling edge, wait for it to be taken, maybe idle after
   task automatic send_beat(op_type op, logic [AMOUNT_W-1:0] amount);
      req_operation <= op;
      req_amount    <= amount;
      req_valid     <= 1'b1;
      offering = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else if (!steady) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // stop offering and wait for every owed reply
   task automatic quiesce();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         @(negedge clock);
      end
      while (pending != 0) @(negedge clock);
   endtask

   // write min_value with junk in the unused bits, then read it back
   task automatic set_min_value(logic [AMOUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      quiesce();
      word = $urandom;
      word[AMOUNT_W-1:0] = value;
      csr_paddr   <= MIN_VALUE_ADDR;
      csr_pwdata  <= word;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      floor_setting = value;
   endtask

   // random mix of all four operations, amounts skewed toward the interesting spots
   task automatic random_mix(int beats, int span);
      op_type              op;
      logic [AMOUNT_W-1:0] amount;
      int                  roll;
      repeat (beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 40)
            op = OP_INSERT;
         else if (roll < 55)
            op = OP_ADD;
         else if (roll < 70)
            op = OP_SUBTRACT;
         else
            op = OP_QUERY;
         roll = $urandom_range(0, 7);
         amount = AMOUNT_W'($urandom);
         case (op)
            OP_INSERT: begin
               if (roll == 0)
                  amount = '0;
               else if (roll == 1)
                  amount = '1;
               else if (roll < 4)
                  amount = floor_setting - 1'b1 + AMOUNT_W'($urandom_range(0, 2));
            end
            OP_ADD, OP_SUBTRACT: begin
               if (roll == 0)
                  amount = '0;
               else if (roll == 1)
                  amount = '1;
               else if (roll < 6)
                  amount = AMOUNT_W'($urandom_range(0, 255));
               else
                  amount = AMOUNT_W'($urandom_range(0, 'h3FFFF));
            end
            default: begin
               if (roll == 0)
                  amount = '0;
               else if (roll == 1)
                  amount = '1;
               else if (roll < 6)
                  amount = AMOUNT_W'($urandom_range(1, span));
               else
                  amount = AMOUNT_W'($urandom_range(0, 2 * span));
            end
         endcase
         send_beat(op, amount);
      end
   endtask

   // receiver: segments of stall patterns, plus a long hold-off on request
   initial begin
      int             seg_left;
      stall_mode_type seg_kind;
      seg_left = 0;
      seg_kind = STALL_NONE;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (seg_left == 0) begin
            seg_kind = stall_mode_type'($urandom_range(0, 3));
            seg_left = $urandom_range(8, 80);
         end
         seg_left--;
         case (seg_kind)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
            default:     rsp_stall <= (seg_left % 3 == 0);
         endcase
      end
   end

   // stimulus and verdict
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: rank zero, short ranks, floor, equal values, offset moves, pruning
      set_min_value(20'd100);
      send_beat(OP_QUERY, '0);
      send_beat(OP_QUERY, 20'd1);
      send_beat(OP_INSERT, 20'd99);
      send_beat(OP_INSERT, '0);
      send_beat(OP_INSERT, 20'd100);
      send_beat(OP_INSERT, '1);
      send_beat(OP_INSERT, 20'd100);
      send_beat(OP_INSERT, 20'd500);
      send_beat(OP_QUERY, 20'd1);
      send_beat(OP_QUERY, 20'd3);
      send_beat(OP_QUERY, 20'd4);
      send_beat(OP_QUERY, 20'd5);
      send_beat(OP_QUERY, '1);
      send_beat(OP_ADD, '0);
      send_beat(OP_ADD, '1);
      send_beat(OP_QUERY, 20'd4);
      send_beat(OP_SUBTRACT, '1);
      send_beat(OP_SUBTRACT, '0);
      send_beat(OP_SUBTRACT, 20'd1);
      send_beat(OP_QUERY, 20'd2);
      // raising the floor leaves stale entries until the next subtract
      set_min_value(20'd600);
      send_beat(OP_QUERY, 20'd2);
      send_beat(OP_INSERT, 20'd600);
      send_beat(OP_SUBTRACT, '0);
      send_beat(OP_QUERY, 20'd2);

      // random traffic under several floors
      set_min_value('0);
      random_mix(150, 20);
      set_min_value(AMOUNT_W'($urandom));
      random_mix(80, 16);
      // long receiver hold-off while the sender keeps pushing
      hold_request = 1'b1;
      steady = 1'b1;
      random_mix(40, 16);
      steady = 1'b0;
      quiesce();
      random_mix(60, 16);
      set_min_value('1);
      random_mix(40, 8);

      // fill the table past its depth
      set_min_value('0);
      for (int i = 0; i < TABLE_DEPTH + 16; i++) begin
         if (i % 64 == 63)
            send_beat(OP_QUERY, AMOUNT_W'($urandom_range(1, i)));
         send_beat(OP_INSERT, AMOUNT_W'($urandom));
      end
      send_beat(OP_QUERY, AMOUNT_W'(TABLE_DEPTH));
      send_beat(OP_QUERY, AMOUNT_W'(TABLE_DEPTH + 1));
      send_beat(OP_QUERY, '1);
      // floor check wins over the full check
      set_min_value(20'h80000);
      send_beat(OP_INSERT, 20'd5);
      send_beat(OP_INSERT, '1);
      send_beat(OP_INSERT, 20'h80000);
      send_beat(OP_QUERY, AMOUNT_W'(TABLE_DEPTH));
      send_beat(OP_SUBTRACT, '0);
      send_beat(OP_QUERY, 20'd1);
      send_beat(OP_SUBTRACT, '1);
      send_beat(OP_QUERY, 20'd1);

      set_min_value(AMOUNT_W'($urandom_range(0, 4096)));
      random_mix(60, 20);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      watch.report_coverage();
      if (fail_count == 0 && pending == 0)
         $display("offset_threshold_rank_table_core regression: pass");
      else
         $display("offset_threshold_rank_table_core regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("offset_threshold_rank_table_core regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
rtl/otrt_pkg.sv
rtl/otrt_cell.sv
rtl/otrt_or_tree.sv
rtl/offset_threshold_rank_table_core.sv
test/offset_threshold_rank_table_checker.sv
test/tb.sv
